// File: hdl/hsd_pkg.sv
`default_nettype none

package hsd_pkg;

    localparam int ANGLE_FRACTION_BITS = 29;
    localparam int CORDIC_ITERATIONS   = 30;
    localparam int SQRT_STEPS          = 32;

    localparam int HALF_SHIFT = 30 - ANGLE_FRACTION_BITS;
    localparam int FULL_SHIFT = 31 - ANGLE_FRACTION_BITS;

    localparam int CW = 36;

    typedef logic signed [CW-1:0] cw_t;
    typedef logic signed [CW-1:0] atan_tab_t [CORDIC_ITERATIONS];

    localparam cw_t Q_ONE          = 36'sd2147483648;
    localparam cw_t Q_PI           = 36'sd6746518852;
    localparam cw_t Q_HALF_PI      = 36'sd3373259426;
    localparam cw_t Q_TWO_PI       = 36'sd13493037705;
    localparam cw_t Q_QUARTER_PI   = 36'sd1686629713;

    function automatic longint unsigned isqrt64(input longint unsigned n);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned b;
        rem = n;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // restoring long division, elaboration time only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic atan_tab_t build_atan_tab();
        atan_tab_t       t;
        longint          acc;
        longint unsigned tu;
        int              sh;
        t[0] = Q_QUARTER_PI;
        for (int i = 1; i < CORDIC_ITERATIONS; i++) begin
            acc = 0;
            for (int k = 0; k < 32; k++) begin
                sh = i * (2 * k + 1);
                if (sh <= 62) begin
                    tu = udiv64(64'd1 << (62 - sh), 64'(2 * k + 1));
                    if ((k & 1) == 1) begin
                        acc = acc - longint'(tu);
                    end else begin
                        acc = acc + longint'(tu);
                    end
                end
            end
            t[i] = CW'((acc + 64'sd1073741824) >>> 31);
        end
        return t;
    endfunction

    function automatic cw_t calc_start_gain();
        longint unsigned g;
        longint unsigned sg;
        g = 64'd1 << 60;
        for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            g = g + (g >> (2 * i));
        end
        sg = isqrt64(g);
        return CW'(udiv64(64'd1 << 61, sg));
    endfunction

    localparam atan_tab_t ATAN_TAB   = build_atan_tab();
    localparam cw_t       START_GAIN = calc_start_gain();

    localparam logic [31:0] RADIUS_RESET = 32'd6371000;

endpackage

`default_nettype wire

// File: hdl/hsd_cordic.sv
`default_nettype none

module hsd_cordic import hsd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic vector_mode,
    input  wire logic in_valid,
    input  wire cw_t  in_x,
    input  wire cw_t  in_y,
    input  wire cw_t  in_z,
    input  wire logic in_tag,
    output logic      out_valid,
    output cw_t       out_x,
    output cw_t       out_y,
    output cw_t       out_z,
    output logic      out_tag
);

    localparam int N = CORDIC_ITERATIONS;

    cw_t  x_reg [N];
    cw_t  y_reg [N];
    cw_t  z_reg [N];
    logic v_reg [N];
    logic t_reg [N];

    cw_t  x_src [N];
    cw_t  y_src [N];
    cw_t  z_src [N];
    logic v_src [N];
    logic t_src [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic up;
        cw_t  x_next;
        cw_t  y_next;
        cw_t  z_next;

        if (i == 0) begin : g_first
            assign x_src[i] = in_x;
            assign y_src[i] = in_y;
            assign z_src[i] = in_z;
            assign v_src[i] = in_valid;
            assign t_src[i] = in_tag;
        end else begin : g_rest
            assign x_src[i] = x_reg[i-1];
            assign y_src[i] = y_reg[i-1];
            assign z_src[i] = z_reg[i-1];
            assign v_src[i] = v_reg[i-1];
            assign t_src[i] = t_reg[i-1];
        end

        assign up = vector_mode ? y_src[i][CW-1] : !z_src[i][CW-1];

        always_comb begin
            if (up) begin
                x_next = x_src[i] - (y_src[i] >>> i);
                y_next = y_src[i] + (x_src[i] >>> i);
                z_next = z_src[i] - ATAN_TAB[i];
            end else begin
                x_next = x_src[i] + (y_src[i] >>> i);
                y_next = y_src[i] - (x_src[i] >>> i);
                z_next = z_src[i] + ATAN_TAB[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_src[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
                t_reg[i] <= t_src[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_x     = x_reg[N-1];
    assign out_y     = y_reg[N-1];
    assign out_z     = z_reg[N-1];
    assign out_tag   = t_reg[N-1];

endmodule

`default_nettype wire

// File: hdl/hsd_isqrt.sv
`default_nettype none

module hsd_isqrt import hsd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [62:0] in_rad_a,
    input  wire logic [62:0] in_rad_b,
    output logic             out_valid,
    output logic [31:0]      out_root_a,
    output logic [31:0]      out_root_b
);

    localparam int N = SQRT_STEPS;

    logic [63:0] na_reg [N];
    logic [63:0] ra_reg [N];
    logic [63:0] nb_reg [N];
    logic [63:0] rb_reg [N];
    logic        v_reg  [N];

    logic [63:0] na_src [N];
    logic [63:0] ra_src [N];
    logic [63:0] nb_src [N];
    logic [63:0] rb_src [N];
    logic        v_src  [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] na_next;
        logic [63:0] ra_next;
        logic [63:0] nb_next;
        logic [63:0] rb_next;

        if (i == 0) begin : g_first
            assign na_src[i] = {1'b0, in_rad_a};
            assign nb_src[i] = {1'b0, in_rad_b};
            assign ra_src[i] = 64'd0;
            assign rb_src[i] = 64'd0;
            assign v_src[i]  = in_valid;
        end else begin : g_rest
            assign na_src[i] = na_reg[i-1];
            assign nb_src[i] = nb_reg[i-1];
            assign ra_src[i] = ra_reg[i-1];
            assign rb_src[i] = rb_reg[i-1];
            assign v_src[i]  = v_reg[i-1];
        end

        always_comb begin
            if (na_src[i] >= ra_src[i] + BIT) begin
                na_next = na_src[i] - (ra_src[i] + BIT);
                ra_next = (ra_src[i] >> 1) + BIT;
            end else begin
                na_next = na_src[i];
                ra_next = ra_src[i] >> 1;
            end
            if (nb_src[i] >= rb_src[i] + BIT) begin
                nb_next = nb_src[i] - (rb_src[i] + BIT);
                rb_next = (rb_src[i] >> 1) + BIT;
            end else begin
                nb_next = nb_src[i];
                rb_next = rb_src[i] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_src[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                na_reg[i] <= na_next;
                ra_reg[i] <= ra_next;
                nb_reg[i] <= nb_next;
                rb_reg[i] <= rb_next;
            end
        end
    end

    assign out_valid  = v_reg[N-1];
    assign out_root_a = ra_reg[N-1][31:0];
    assign out_root_b = rb_reg[N-1][31:0];

endmodule

`default_nettype wire

// File: hdl/haversine_sphere_distance.sv
// Great-circle distance between two points on a sphere.
// Request channel s_*: one request carries two lat/lon points in radians,
// signed fixed point with 29 fraction bits. Result channel m_*: the distance
// in radius units, rounded to nearest. cfg_wr_en/cfg_wr_data load the sphere
// radius (reset value 6371000); write it only while no request is in flight.
// Pipeline: input angle stage, wrap and fold stages, 30-stage sin/cos
// CORDIC, three multiply stages, 32-stage square root pair, 30-stage atan2
// CORDIC, clamp, and a two-stage radius multiply ending in the output
// register.
// Throughput: one request per cycle; every stage advances in lockstep.
// Stall: while m_tvalid is high and m_tready low, the whole pipeline holds
// and s_tready is low; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// default radius.
`default_nettype none

module haversine_sphere_distance import hsd_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // first_lat[30:0], first_lon[62:31], second_lat[93:63], second_lon[125:94]
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // surface_distance[33:0]
    output logic [39:0]       m_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic [31:0]  cfg_wr_data
);

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic [31:0] radius_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_wr_en) begin
            radius_reg <= cfg_wr_data;
        end
    end

    cw_t lat1, lon1, lat2, lon2;
    assign lat1 = {{5{s_tdata[30]}},  s_tdata[30:0]};
    assign lon1 = {{4{s_tdata[62]}},  s_tdata[62:31]};
    assign lat2 = {{5{s_tdata[93]}},  s_tdata[93:63]};
    assign lon2 = {{4{s_tdata[125]}}, s_tdata[125:94]};

    // lanes: 0 dlat/2, 1 dlon/2, 2 lat1, 3 lat2
    cw_t  ang_next [4];
    cw_t  ang_reg  [4];
    cw_t  wrap_reg [4];
    cw_t  fold_reg [4];
    logic neg_reg  [4];
    logic a_vld_reg, w_vld_reg, f_vld_reg;

    assign ang_next[0] = (lat2 - lat1) <<< HALF_SHIFT;
    assign ang_next[1] = (lon2 - lon1) <<< HALF_SHIFT;
    assign ang_next[2] = lat1 <<< FULL_SHIFT;
    assign ang_next[3] = lat2 <<< FULL_SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            w_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= s_tvalid;
            w_vld_reg <= a_vld_reg;
            f_vld_reg <= w_vld_reg;
        end
    end

    cw_t  sc_cos [4];
    cw_t  sc_sin [4];
    logic sc_vld [4];

    for (genvar l = 0; l < 4; l++) begin : g_lane
        cw_t  wrap_next;
        cw_t  fold_next;
        logic neg_next;

        always_comb begin
            if (ang_reg[l] > Q_PI) begin
                wrap_next = ang_reg[l] - Q_TWO_PI;
            end else if (ang_reg[l] < -Q_PI) begin
                wrap_next = ang_reg[l] + Q_TWO_PI;
            end else begin
                wrap_next = ang_reg[l];
            end
        end

        always_comb begin
            if (wrap_reg[l] > Q_HALF_PI) begin
                fold_next = Q_PI - wrap_reg[l];
                neg_next  = 1'b1;
            end else if (wrap_reg[l] < -Q_HALF_PI) begin
                fold_next = -Q_PI - wrap_reg[l];
                neg_next  = 1'b1;
            end else begin
                fold_next = wrap_reg[l];
                neg_next  = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                ang_reg[l]  <= ang_next[l];
                wrap_reg[l] <= wrap_next;
                fold_reg[l] <= fold_next;
                neg_reg[l]  <= neg_next;
            end
        end

        cw_t  rx;
        logic rtag;

        hsd_cordic u_rot (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (adv),
            .vector_mode (1'b0),
            .in_valid    (f_vld_reg),
            .in_x        (START_GAIN),
            .in_y        ('0),
            .in_z        (fold_reg[l]),
            .in_tag      (neg_reg[l]),
            .out_valid   (sc_vld[l]),
            .out_x       (rx),
            .out_y       (sc_sin[l]),
            .out_z       (),
            .out_tag     (rtag)
        );

        assign sc_cos[l] = rtag ? -rx : rx;
    end

    // haversine term
    logic signed [33:0] slat, slon, c1, c2;
    assign slat = sc_sin[0][33:0];
    assign slon = sc_sin[1][33:0];
    assign c1   = sc_cos[2][33:0];
    assign c2   = sc_cos[3][33:0];

    logic signed [67:0] sa2_p, sl2_p, c12_p;
    assign sa2_p = (slat * slat + 68'sd1073741824) >>> 31;
    assign sl2_p = (slon * slon + 68'sd1073741824) >>> 31;
    assign c12_p = (c1 * c2 + 68'sd1073741824) >>> 31;

    logic signed [33:0] sa2_reg, sl2_reg, c12_reg, sa2b_reg, prod_reg;
    logic [31:0]        a_reg;
    logic               m1_vld_reg, m2_vld_reg, m3_vld_reg;

    logic signed [67:0] prod_p;
    assign prod_p = (c12_reg * sl2_reg + 68'sd1073741824) >>> 31;

    logic signed [34:0] a_sum;
    logic [31:0]        a_next;
    assign a_sum = 35'(sa2b_reg) + 35'(prod_reg);

    always_comb begin
        if (a_sum < 35'sd0) begin
            a_next = 32'd0;
        end else if (a_sum > 35'(Q_ONE)) begin
            a_next = Q_ONE[31:0];
        end else begin
            a_next = a_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
        end else if (adv) begin
            m1_vld_reg <= sc_vld[0];
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa2_reg  <= sa2_p[33:0];
            sl2_reg  <= sl2_p[33:0];
            c12_reg  <= c12_p[33:0];
            sa2b_reg <= sa2_reg;
            prod_reg <= prod_p[33:0];
            a_reg    <= a_next;
        end
    end

    // central angle
    logic [31:0] one_minus_a;
    assign one_minus_a = Q_ONE[31:0] - a_reg;

    logic        sq_vld;
    logic [31:0] ys, xs;

    hsd_isqrt u_sqrt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (m3_vld_reg),
        .in_rad_a   ({a_reg, 31'd0}),
        .in_rad_b   ({one_minus_a, 31'd0}),
        .out_valid  (sq_vld),
        .out_root_a (ys),
        .out_root_b (xs)
    );

    logic vec_vld;
    cw_t  vec_z;

    hsd_cordic u_vec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .vector_mode (1'b1),
        .in_valid    (sq_vld),
        .in_x        ({4'd0, xs}),
        .in_y        ({4'd0, ys}),
        .in_z        ('0),
        .in_tag      (1'b0),
        .out_valid   (vec_vld),
        .out_x       (),
        .out_y       (),
        .out_z       (vec_z),
        .out_tag     ()
    );

    logic signed [36:0] z2;
    logic [32:0]        cu_next;
    assign z2 = {vec_z, 1'b0};

    always_comb begin
        if (z2 < 37'sd0) begin
            cu_next = 33'd0;
        end else if (z2 > 37'(Q_PI)) begin
            cu_next = Q_PI[32:0];
        end else begin
            cu_next = z2[32:0];
        end
    end

    logic [32:0] cu_reg;
    logic [48:0] plo_reg, phi_reg;
    logic        cu_vld_reg, p_vld_reg, out_vld_reg;
    logic [33:0] dist_reg;

    logic [65:0] dist_sum;
    assign dist_sum = {1'b0, phi_reg, 16'd0} + {17'd0, plo_reg} + 66'd1073741824;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cu_vld_reg  <= 1'b0;
            p_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            cu_vld_reg  <= vec_vld;
            p_vld_reg   <= cu_vld_reg;
            out_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cu_reg   <= cu_next;
            plo_reg  <= cu_reg * radius_reg[15:0];
            phi_reg  <= cu_reg * radius_reg[31:16];
            dist_reg <= dist_sum[64:31];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, dist_reg};

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    a_dist_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:0] <= 34'd13493037702))
        else $error("distance above half circumference bound");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_angle_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        cu_vld_reg |-> (cu_reg <= Q_PI[32:0]))
        else $error("central angle out of range");
`endif

endmodule

`default_nettype wire
